### hdl/axis_angle_rotate3_unit_defines.svh
// Assertion macros shared by the axis-angle rotation block.
// No dependencies; included by files that carry assertions.
`ifndef AXIS_ANGLE_ROTATE3_UNIT_DEFINES_SVH
`define AXIS_ANGLE_ROTATE3_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define AAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define AAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/aar_pkg.sv
// Types, constants and helper functions for the axis-angle rotation block.
// No dependencies.
`default_nettype none
package aar_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

    // atan(2^-i), 2^32 per turn
    localparam logic [29:0] ATAN_TURN [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic        [31:0] turn_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] rotated_x;
        logic signed [31:0] rotated_y;
        logic signed [31:0] rotated_z;
        logic               clipped;
    } t_out_item;

    // one CORDIC pipeline slot
    typedef struct packed {
        logic               valid;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic        [1:0]  quad;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
    } t_cordic;

    // operands handed to the matrix pipeline
    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic signed [32:0] t;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } t_mat_in;

    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v > ONE_Q30) ? ONE_Q30 : ((v < -ONE_Q30) ? -ONE_Q30 : v);
        return r[31:0];
    endfunction

    // floor((p + 2^29) / 2^30)
    function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
        logic signed [65:0] r;
        r = (p + 66'sd536870912) >>> 30;
        return r[35:0];
    endfunction

endpackage
`default_nettype wire

### hdl/axis_angle_rotate3_unit.sv
// Axis-angle (Rodrigues) rotation of a Q15.16 point about a Q1.30 axis.
// Depends on aar_pkg, aar_cordic_stage, aar_matrix and the defines header.
//
// Takes one transfer per clock while the output is not stalled and returns
// one result per input, in order. The pipeline holds one register per
// CORDIC rotation step, then five matrix stages (axis products, times t,
// matrix entries, entry*point, row sum with round and saturate). The whole
// pipeline shares one enable, so a stalled output freezes every stage and
// nothing is dropped or repeated; o_ready is high whenever the output
// register is empty or being taken. The axis is clamped to +-1 but not
// normalized; clipped flags any saturated component.
`default_nettype none
`include "axis_angle_rotate3_unit_defines.svh"
module axis_angle_rotate3_unit
    import aar_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    logic    w_en;
    t_cordic w_slot [CORDIC_STEPS+1];
    t_cordic w_last;
    t_mat_in w_op;
    logic signed [33:0] w_c;
    logic signed [33:0] w_s;

    // global stall: advance when the output register is free or drained
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // CORDIC seed: gain on x, low 30 angle bits on z, quadrant rides along
    always_comb begin
        w_slot[0].valid = i_valid;
        w_slot[0].x     = GAIN_Q30;
        w_slot[0].y     = '0;
        w_slot[0].z     = $signed({3'b000, i_data.turn_angle[29:0]});
        w_slot[0].quad  = i_data.turn_angle[31:30];
        w_slot[0].px    = i_data.point_x;
        w_slot[0].py    = i_data.point_y;
        w_slot[0].pz    = i_data.point_z;
        w_slot[0].ax    = clamp_q30(34'(i_data.axis_x));
        w_slot[0].ay    = clamp_q30(34'(i_data.axis_y));
        w_slot[0].az    = clamp_q30(34'(i_data.axis_z));
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        aar_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_step  (STEP_W'(k)),
            .i_slot  (w_slot[k]),
            .o_slot  (w_slot[k+1])
        );
    end

    assign w_last = w_slot[CORDIC_STEPS];

    // quadrant fold by exact negation/swap, then clamp
    always_comb begin
        case (w_last.quad)
            2'd0: begin
                w_c = w_last.x;
                w_s = w_last.y;
            end
            2'd1: begin
                w_c = -w_last.y;
                w_s = w_last.x;
            end
            2'd2: begin
                w_c = -w_last.x;
                w_s = -w_last.y;
            end
            default: begin
                w_c = w_last.y;
                w_s = -w_last.x;
            end
        endcase
        w_op.c  = clamp_q30(w_c);
        w_op.s  = clamp_q30(w_s);
        w_op.t  = 33'(ONE_Q30) - 33'(w_op.c);
        w_op.ax = w_last.ax;
        w_op.ay = w_last.ay;
        w_op.az = w_last.az;
        w_op.px = w_last.px;
        w_op.py = w_last.py;
        w_op.pz = w_last.pz;
    end

    aar_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_last.valid),
        .i_op    (w_op),
        .o_valid (o_valid),
        .o_item  (o_data)
    );

    `AAR_ASSERT_NOW(a_clip_extreme, o_valid && o_data.clipped,
        o_data.rotated_x == 32'sh7fffffff || o_data.rotated_x == 32'sh80000000 ||
        o_data.rotated_y == 32'sh7fffffff || o_data.rotated_y == 32'sh80000000 ||
        o_data.rotated_z == 32'sh7fffffff || o_data.rotated_z == 32'sh80000000,
        "clipped set with no saturated component")
    `AAR_ASSERT_NOW(a_empty_ready, !o_valid, o_ready,
        "input stalled while output register empty")
    `AAR_ASSERT_NOW(a_stall_back, o_valid && !i_ready, !o_ready,
        "input taken while output stalled")
    `AAR_ASSERT_NEXT(a_hold_last, o_valid && !i_ready, o_valid,
        "pending result lost during stall")

endmodule
`default_nettype wire

### hdl/aar_cordic_stage.sv
// One registered CORDIC rotation step with its riding payload.
// Depends on aar_pkg.
`default_nettype none
module aar_cordic_stage
    import aar_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic [STEP_W-1:0]  i_step,
    input  wire t_cordic            i_slot,
    output t_cordic                 o_slot
);

    t_cordic r_slot;
    logic    r_valid;
    t_cordic n_slot;
    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;
    logic signed [32:0] w_ang;

    always_comb begin
        w_dx   = i_slot.y >>> i_step;
        w_dy   = i_slot.x >>> i_step;
        w_ang  = $signed({3'b000, ATAN_TURN[i_step]});
        n_slot = i_slot;
        if (i_slot.z >= 0) begin
            n_slot.x = i_slot.x - w_dx;
            n_slot.y = i_slot.y + w_dy;
            n_slot.z = i_slot.z - w_ang;
        end else begin
            n_slot.x = i_slot.x + w_dx;
            n_slot.y = i_slot.y - w_dy;
            n_slot.z = i_slot.z + w_ang;
        end
    end

    // valid bit is reset; the payload is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_slot <= n_slot;
        end
    end

    always_comb begin
        o_slot       = r_slot;
        o_slot.valid = r_valid;
    end

endmodule
`default_nettype wire

### hdl/aar_matrix.sv
// Five-stage pipeline: builds the Rodrigues matrix from c, s, t and the
// axis, applies it to the point, rounds and saturates. Depends on aar_pkg.
`default_nettype none
module aar_matrix
    import aar_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_valid,
    input  wire t_mat_in   i_op,
    output logic           o_valid,
    output t_out_item      o_item
);

    logic [4:0] r_v;

    // stage A: axis*axis and axis*s
    logic signed [63:0] r_a_pp [6];
    logic signed [63:0] r_a_ps [3];
    logic signed [31:0] r_a_c;
    logic signed [32:0] r_a_t;
    logic signed [31:0] r_a_p  [3];

    // stage B: rounded products times t
    logic signed [64:0] r_b_ppt [6];
    logic signed [31:0] r_b_s   [3];
    logic signed [31:0] r_b_c;
    logic signed [31:0] r_b_p   [3];

    // stage C: matrix entries, row major
    logic signed [34:0] r_c_m [9];
    logic signed [31:0] r_c_p [3];

    // stage D: entry*point, floor shifted by 2
    logic signed [66:0] r_d_q [9];

    t_out_item r_out;

    logic signed [31:0] w_q   [6];
    logic signed [32:0] w_tt  [6];
    logic signed [34:0] w_c;
    logic signed [34:0] w_s   [3];
    logic signed [66:0] w_prod [9];
    logic signed [68:0] w_sum [3];
    logic signed [68:0] w_rnd [3];
    logic signed [31:0] w_sat [3];
    logic [2:0]         w_clip;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_q[k]  = 32'(rnd30(66'(r_a_pp[k])));
            w_tt[k] = 33'(rnd30(66'(r_b_ppt[k])));
        end
        w_c = 35'(r_b_c);
        for (int k = 0; k < 3; k++) begin
            w_s[k] = 35'(r_b_s[k]);
        end
        for (int k = 0; k < 9; k++) begin
            w_prod[k] = 67'(r_c_m[k]) * 67'(r_c_p[k % 3]);
        end
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = 69'(r_d_q[3*r]) + 69'(r_d_q[3*r+1]) + 69'(r_d_q[3*r+2]);
            w_rnd[r] = (w_sum[r] + 69'sd134217728) >>> 28;
            if (w_rnd[r] > 69'sd2147483647) begin
                w_sat[r]  = 32'sh7fffffff;
                w_clip[r] = 1'b1;
            end else if (w_rnd[r] < -69'sd2147483648) begin
                w_sat[r]  = 32'sh80000000;
                w_clip[r] = 1'b1;
            end else begin
                w_sat[r]  = w_rnd[r][31:0];
                w_clip[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // A
            r_a_pp[0] <= i_op.ax * i_op.ax;
            r_a_pp[1] <= i_op.ay * i_op.ay;
            r_a_pp[2] <= i_op.az * i_op.az;
            r_a_pp[3] <= i_op.ax * i_op.ay;
            r_a_pp[4] <= i_op.ax * i_op.az;
            r_a_pp[5] <= i_op.ay * i_op.az;
            r_a_ps[0] <= i_op.ax * i_op.s;
            r_a_ps[1] <= i_op.ay * i_op.s;
            r_a_ps[2] <= i_op.az * i_op.s;
            r_a_c     <= i_op.c;
            r_a_t     <= i_op.t;
            r_a_p[0]  <= i_op.px;
            r_a_p[1]  <= i_op.py;
            r_a_p[2]  <= i_op.pz;
            // B
            for (int k = 0; k < 6; k++) begin
                r_b_ppt[k] <= 65'(w_q[k]) * 65'(r_a_t);
            end
            for (int k = 0; k < 3; k++) begin
                r_b_s[k] <= 32'(rnd30(66'(r_a_ps[k])));
                r_b_p[k] <= r_a_p[k];
            end
            r_b_c <= r_a_c;
            // C: xx yy zz xy xz yz at 0..5
            r_c_m[0] <= w_c + 35'(w_tt[0]);
            r_c_m[1] <= 35'(w_tt[3]) - w_s[2];
            r_c_m[2] <= 35'(w_tt[4]) + w_s[1];
            r_c_m[3] <= 35'(w_tt[3]) + w_s[2];
            r_c_m[4] <= w_c + 35'(w_tt[1]);
            r_c_m[5] <= 35'(w_tt[5]) - w_s[0];
            r_c_m[6] <= 35'(w_tt[4]) - w_s[1];
            r_c_m[7] <= 35'(w_tt[5]) + w_s[0];
            r_c_m[8] <= w_c + 35'(w_tt[2]);
            for (int k = 0; k < 3; k++) begin
                r_c_p[k] <= r_b_p[k];
            end
            // D
            for (int k = 0; k < 9; k++) begin
                r_d_q[k] <= w_prod[k] >>> 2;
            end
            // E
            r_out.rotated_x <= w_sat[0];
            r_out.rotated_y <= w_sat[1];
            r_out.rotated_z <= w_sat[2];
            r_out.clipped   <= |w_clip;
        end
    end

    assign o_valid = r_v[4];
    assign o_item  = r_out;

endmodule
`default_nettype wire
